// ===== src/pps_pkg.sv =====
// Shared types, constants and helpers for the pulsing position sweep block.
`default_nettype none

package pps_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TIME_W     = 20;
	localparam int POINT_W    = 16;
	localparam int POS_W      = 32;
	localparam int VEL_W      = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SWEEP_MODE     = 2'd0,
		CFG_FIRST_POINT    = 2'd1,
		CFG_SECOND_POINT   = 2'd2,
		CFG_START_VELOCITY = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		MODE_CYCLIC  = 1'b0,
		MODE_ACYCLIC = 1'b1
	} sweep_mode_t;

	localparam logic HEADING_SECOND = 1'b1;

	typedef struct packed {
		sweep_mode_t                sweep_mode;
		logic signed [POINT_W-1:0]  first_point;
		logic signed [POINT_W-1:0]  second_point;
		logic signed [VEL_W-1:0]    start_velocity;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [VEL_W-1:0] velocity;
		logic             heading;
	} state_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] coord;
		logic signed [POINT_W:0]   coord_rounded_up;
		logic                      coord_changed;
		logic                      turned;
		logic                      heading_second;
	} result_t;

	// Integer coordinate to 16.16 fixed point.
	function automatic logic [POS_W-1:0] fix_of(input logic [POINT_W-1:0] p);
		return {p, {FRAC_BITS{1'b0}}};
	endfunction

endpackage

`default_nettype wire

// ===== src/pps_cfg_regs.sv =====
// Configuration register file for the pulsing position sweep block.
`default_nettype none

module pps_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [pps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output pps_pkg::cfg_t                           cfg
);
	import pps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_mode     <= MODE_CYCLIC;
			cfg_q.first_point    <= '0;
			cfg_q.second_point   <= '0;
			cfg_q.start_velocity <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_SWEEP_MODE:     cfg_q.sweep_mode     <= sweep_mode_t'(cfg_wdata[0]);
				CFG_FIRST_POINT:    cfg_q.first_point    <= cfg_wdata[POINT_W-1:0];
				CFG_SECOND_POINT:   cfg_q.second_point   <= cfg_wdata[POINT_W-1:0];
				CFG_START_VELOCITY: cfg_q.start_velocity <= cfg_wdata[VEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/pps_step.sv =====
// Combinational step update: motion, overshoot test, reflection or wrap, restart and result fields.
`default_nettype none

module pps_step (
	input  wire pps_pkg::cfg_t                  cfg,
	input  wire pps_pkg::state_t                cur,
	input  wire logic [pps_pkg::TIME_W-1:0]     time_step,
	input  wire logic                           restart,
	output pps_pkg::state_t                     nxt,
	output pps_pkg::result_t                    res
);
	import pps_pkg::*;

	logic signed [TIME_W+VEL_W:0] prod;
	logic [POS_W-1:0]             pos_moved;
	logic [POS_W-1:0]             target;
	logic [POS_W-1:0]             disp;
	logic                         overshoot;
	logic [POINT_W-1:0]           coord_new;

	always_comb begin
		// Signed product of an unsigned time and a signed velocity; bits 47:16 are the move.
		prod      = $signed({1'b0, time_step}) * $signed(cur.velocity);
		pos_moved = cur.position + prod[FRAC_BITS+POS_W-1:FRAC_BITS];

		if (cfg.sweep_mode == MODE_CYCLIC) begin
			target = (cur.heading == HEADING_SECOND) ? fix_of(cfg.second_point)
			                                          : fix_of(cfg.first_point);
		end else begin
			target = fix_of(cfg.second_point);
		end
		disp = target - pos_moved;

		// Overshoot when both are nonzero and their signs differ.
		overshoot = (cur.velocity != '0) && (disp != '0) &&
		            (cur.velocity[VEL_W-1] != disp[POS_W-1]);

		nxt = cur;
		if (restart) begin
			nxt.position = fix_of(cfg.first_point);
			nxt.velocity = cfg.start_velocity;
			nxt.heading  = HEADING_SECOND;
		end else if (overshoot) begin
			if (cfg.sweep_mode == MODE_CYCLIC) begin
				nxt.position = target + disp;
				nxt.heading  = ~cur.heading;
				nxt.velocity = '0 - cur.velocity;
			end else begin
				nxt.position = fix_of(cfg.first_point) + disp;
			end
		end else begin
			nxt.position = pos_moved;
		end

		coord_new            = nxt.position[POS_W-1:FRAC_BITS];
		res.coord            = coord_new;
		res.coord_rounded_up = {coord_new[POINT_W-1], coord_new} +
		                       {{POINT_W{1'b0}}, (nxt.position[FRAC_BITS-1:0] != '0)};
		res.coord_changed    = (coord_new != cur.position[POS_W-1:FRAC_BITS]);
		res.turned           = ~restart & overshoot;
		res.heading_second   = nxt.heading;
	end

endmodule

`default_nettype wire

// ===== src/pulsing_position_sweep.sv =====
// Top level of the pulsing position sweep oscillator with stream ports.
`default_nettype none

// The block advances a 16.16 fixed-point position by (time_step * velocity) >> 16 for
// every input item and returns one result item per input item, in order. In cyclic
// mode the position bounces between first_point and second_point (triangle wave);
// in acyclic mode it jumps back to first_point after passing second_point (sawtooth).
// An item with restart set reloads position and velocity from the configuration
// registers and sets heading toward second_point, without moving. The block takes
// one item per clock cycle when the output side keeps up: the step update (one 21x32
// multiply, the add and the overshoot test) sits between the input register and the
// result register, so an item waits in the input register and its result is then
// registered in the result register, from which it is taken. The loop through the
// position and velocity registers closes through that combinational step update.
// Configuration writes are expected only while no item is in flight; sweep_mode,
// first_point and second_point are used live, start_velocity only at a restart.

module pulsing_position_sweep (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write port.
	input  wire logic                               cfg_we,
	input  wire logic [pps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [pps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Input items.
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [pps_pkg::IN_DATA_W-1:0]      s_tdata,  // [19:0] time_step, rest zero
	input  wire logic                               s_tuser,  // [0] restart
	// Result items.
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [pps_pkg::OUT_DATA_W-1:0]          m_tdata   // [15:0] coord,
	                                                          // [32:16] coord_rounded_up,
	                                                          // [33] coord_changed,
	                                                          // [34] turned,
	                                                          // [35] heading_second,
	                                                          // [39:36] zero
);
	import pps_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;

	logic              in_valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              restart_s1;
	logic              out_valid_q;
	logic              advance;

	pps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pps_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.time_step (time_s1),
		.restart   (restart_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// The held item moves into the result register whenever that register is free
	// or being emptied in the same cycle; the input register then frees up too.
	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			time_s1    <= s_tdata[TIME_W-1:0];
			restart_s1 <= s_tuser;
		end
	end

	// State follows the item that leaves the input register. Reset matches a
	// restart with the reset configuration: position and velocity zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position <= '0;
			state_q.velocity <= '0;
			state_q.heading  <= HEADING_SECOND;
			out_valid_q      <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.heading_second, res_q.turned, res_q.coord_changed,
	                   res_q.coord_rounded_up, res_q.coord};

endmodule

`default_nettype wire
